### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

### rtl/flpq_pkg.sv
// ----------------------------------------------------------------------------
// flpq_pkg
// Types, sizes and helpers for the five level priority queue.
// ----------------------------------------------------------------------------
package flpq_pkg;

    localparam int LEVELS      = 5;
    localparam int LEVEL_DEPTH = 16;
    localparam int MAX_RESULTS = 64;

    localparam int LVW   = $clog2(LEVELS);
    localparam int IDXW  = $clog2(LEVEL_DEPTH);
    localparam int CNTW  = $clog2(LEVEL_DEPTH + 1);
    localparam int ADDRW = $clog2(LEVELS * LEVEL_DEPTH);
    localparam int ENTW  = 48;

    typedef enum logic [1:0] {
        KIND_SEND     = 2'd0,
        KIND_ANNOUNCE = 2'd1,
        KIND_REMOVE   = 2'd2,
        KIND_PROMOTE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ANN_RD,
        S_ANN_OUT,
        S_WALK_INIT,
        S_WALK_RD,
        S_WALK_WR
    } state_t;

    // index within a level, wrapped at the level depth
    function automatic logic [IDXW-1:0] wrap_idx(logic [IDXW-1:0] base,
                                                 logic [CNTW-1:0] k);
        logic [CNTW:0] s;
        s = {1'b0, CNTW'(base)} + {1'b0, k};
        if (s >= (CNTW+1)'(LEVEL_DEPTH))
            s = s - (CNTW+1)'(LEVEL_DEPTH);
        return s[IDXW-1:0];
    endfunction

    function automatic logic [ADDRW-1:0] slot_addr(logic [LVW-1:0] lv,
                                                   logic [IDXW-1:0] idx);
        return ADDRW'(int'(lv) * LEVEL_DEPTH + int'(idx));
    endfunction

endpackage

### rtl/five_level_priority_queue_purge.sv
// ----------------------------------------------------------------------------
// five_level_priority_queue_purge
// Strict-priority store of five FIFO levels held in one entry memory.
// ----------------------------------------------------------------------------
// A request is taken on a rising edge with start high and busy low; kind
// selects send, announce, remove-by-sender or promote-by-sender.
// Each result appears for one cycle with strobe high; last marks the final
// result of a request. The receiver cannot hold results off.
// Send: one result the cycle after the request, busy stays low.
// Announce: one result per popped entry, each a memory read then output,
//   highest level first; count zero or empty store gives status 2.
// Remove / promote: walk every live entry of the affected levels, each one
//   read and then written back to its level, moved one level up or dropped,
//   with a setup step per level.
// Reset clears heads, counts and control; the entry memory is not cleared,
// only live entries are ever read.
// ----------------------------------------------------------------------------
module five_level_priority_queue_purge
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [15:0] sender_id,
    input  logic [2:0]  level,
    input  logic [31:0] payload,
    input  logic [6:0]  announce_count,
    output logic        strobe,
    output logic [1:0]  status,
    output logic [15:0] out_sender,
    output logic [2:0]  out_level,
    output logic [31:0] out_payload,
    output logic [6:0]  moved_count,
    output logic        last
);

    localparam int NL  = flpq_pkg::LEVELS;
    localparam int LW  = flpq_pkg::LVW;
    localparam int IW  = flpq_pkg::IDXW;
    localparam int CW  = flpq_pkg::CNTW;
    localparam int AW  = flpq_pkg::ADDRW;
    localparam int EW  = flpq_pkg::ENTW;

    flpq_pkg::state_t state_reg, state_next;

    logic [IW-1:0] head_reg  [NL];
    logic [IW-1:0] head_next [NL];
    logic [CW-1:0] count_reg  [NL];
    logic [CW-1:0] count_next [NL];

    logic          promote_reg, promote_next;
    logic [15:0]   snd_reg, snd_next;
    logic [LW-1:0] lv_reg, lv_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] j_reg, j_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic [6:0]    moved_reg, moved_next;
    logic          full_reg, full_next;
    logic          alast_reg, alast_next;

    logic          strobe_reg, strobe_next;
    logic [1:0]    status_reg, status_next;
    logic [15:0]   sender_reg, sender_next;
    logic [2:0]    level_reg, level_next;
    logic [31:0]   payload_reg, payload_next;
    logic [6:0]    mcount_reg, mcount_next;
    logic          last_reg, last_next;

    // entry memory: sender in the upper 16 bits
    logic [EW-1:0] mem [NL * flpq_pkg::LEVEL_DEPTH];
    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rd_q;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rd_q <= mem[raddr];
    end

    // highest non-empty level and whether any lower level holds entries
    logic          any_live;
    logic [LW-1:0] top_lv;
    logic          more_below;

    always_comb
    begin
        any_live   = 1'b0;
        top_lv     = '0;
        more_below = 1'b0;
        for (int l = NL - 1; l >= 0; l--)
        begin
            if (count_reg[l] != '0)
            begin
                any_live = 1'b1;
                top_lv   = LW'(l);
            end
        end
        for (int l = 0; l < NL; l++)
        begin
            if (LW'(l) > top_lv && count_reg[l] != '0)
                more_below = 1'b1;
        end
    end

    logic [6:0] cnt_clip;
    assign cnt_clip = (announce_count > 7'(flpq_pkg::MAX_RESULTS))
                      ? 7'(flpq_pkg::MAX_RESULTS) : announce_count;

    logic          match;
    logic [LW-1:0] up_lv;
    assign match = (rd_q[EW-1:32] == snd_reg);
    assign up_lv = lv_reg - LW'(1);

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        promote_next = promote_reg;
        snd_next     = snd_reg;
        lv_next      = lv_reg;
        n_next       = n_reg;
        j_next       = j_reg;
        cnt_next     = cnt_reg;
        moved_next   = moved_reg;
        full_next    = full_reg;
        alast_next   = alast_reg;
        strobe_next  = 1'b0;
        status_next  = status_reg;
        sender_next  = sender_reg;
        level_next   = level_reg;
        payload_next = payload_reg;
        mcount_next  = mcount_reg;
        last_next    = last_reg;
        we    = 1'b0;
        re    = 1'b0;
        waddr = '0;
        raddr = '0;
        wdata = '0;

        case (state_reg)
            flpq_pkg::S_IDLE:
            begin
                if (start)
                begin
                    snd_next   = sender_id;
                    moved_next = '0;
                    full_next  = 1'b0;
                    case (flpq_pkg::kind_t'(kind))
                        flpq_pkg::KIND_SEND:
                        begin
                            strobe_next  = 1'b1;
                            sender_next  = '0;
                            level_next   = '0;
                            payload_next = '0;
                            mcount_next  = '0;
                            last_next    = 1'b1;
                            if (level >= 3'(NL) ||
                                count_reg[LW'(level)] >= CW'(flpq_pkg::LEVEL_DEPTH))
                            begin
                                status_next = flpq_pkg::ST_FULL;
                            end
                            else
                            begin
                                status_next = flpq_pkg::ST_OK;
                                we    = 1'b1;
                                waddr = flpq_pkg::slot_addr(LW'(level),
                                        flpq_pkg::wrap_idx(head_reg[LW'(level)],
                                                           count_reg[LW'(level)]));
                                wdata = {sender_id, payload};
                                count_next[LW'(level)] = count_reg[LW'(level)] + CW'(1);
                            end
                        end
                        flpq_pkg::KIND_ANNOUNCE:
                        begin
                            if (cnt_clip == '0 || !any_live)
                            begin
                                strobe_next  = 1'b1;
                                status_next  = flpq_pkg::ST_EMPTY;
                                sender_next  = '0;
                                level_next   = '0;
                                payload_next = '0;
                                mcount_next  = '0;
                                last_next    = 1'b1;
                            end
                            else
                            begin
                                cnt_next   = cnt_clip;
                                state_next = flpq_pkg::S_ANN_RD;
                            end
                        end
                        flpq_pkg::KIND_REMOVE:
                        begin
                            promote_next = 1'b0;
                            lv_next      = '0;
                            state_next   = flpq_pkg::S_WALK_INIT;
                        end
                        default:
                        begin
                            promote_next = 1'b1;
                            lv_next      = LW'(1);
                            state_next   = flpq_pkg::S_WALK_INIT;
                        end
                    endcase
                end
            end

            flpq_pkg::S_ANN_RD:
            begin
                // pop the head of the highest live level
                re    = 1'b1;
                raddr = flpq_pkg::slot_addr(top_lv, head_reg[top_lv]);
                head_next[top_lv]  = flpq_pkg::wrap_idx(head_reg[top_lv], CW'(1));
                count_next[top_lv] = count_reg[top_lv] - CW'(1);
                lv_next    = top_lv;
                cnt_next   = cnt_reg - 7'd1;
                alast_next = (cnt_reg == 7'd1) ||
                             (count_reg[top_lv] == CW'(1) && !more_below);
                state_next = flpq_pkg::S_ANN_OUT;
            end

            flpq_pkg::S_ANN_OUT:
            begin
                strobe_next  = 1'b1;
                status_next  = flpq_pkg::ST_OK;
                sender_next  = rd_q[EW-1:32];
                level_next   = 3'(lv_reg);
                payload_next = rd_q[31:0];
                mcount_next  = '0;
                last_next    = alast_reg;
                state_next   = alast_reg ? flpq_pkg::S_IDLE : flpq_pkg::S_ANN_RD;
            end

            flpq_pkg::S_WALK_INIT:
            begin
                n_next     = count_reg[lv_reg];
                j_next     = '0;
                state_next = flpq_pkg::S_WALK_RD;
            end

            flpq_pkg::S_WALK_RD:
            begin
                if (j_reg == n_reg)
                begin
                    if (lv_reg == LW'(NL - 1))
                    begin
                        strobe_next  = 1'b1;
                        status_next  = full_reg ? flpq_pkg::ST_FULL : flpq_pkg::ST_OK;
                        sender_next  = '0;
                        level_next   = '0;
                        payload_next = '0;
                        mcount_next  = moved_reg;
                        last_next    = 1'b1;
                        state_next   = flpq_pkg::S_IDLE;
                    end
                    else
                    begin
                        lv_next    = lv_reg + LW'(1);
                        state_next = flpq_pkg::S_WALK_INIT;
                    end
                end
                else
                begin
                    re    = 1'b1;
                    raddr = flpq_pkg::slot_addr(lv_reg, head_reg[lv_reg]);
                    head_next[lv_reg]  = flpq_pkg::wrap_idx(head_reg[lv_reg], CW'(1));
                    count_next[lv_reg] = count_reg[lv_reg] - CW'(1);
                    state_next = flpq_pkg::S_WALK_WR;
                end
            end

            flpq_pkg::S_WALK_WR:
            begin
                j_next     = j_reg + CW'(1);
                state_next = flpq_pkg::S_WALK_RD;
                wdata      = rd_q;
                if (match && !promote_reg)
                begin
                    moved_next = moved_reg + 7'd1;
                end
                else if (match && promote_reg &&
                         count_reg[up_lv] < CW'(flpq_pkg::LEVEL_DEPTH))
                begin
                    moved_next = moved_reg + 7'd1;
                    we    = 1'b1;
                    waddr = flpq_pkg::slot_addr(up_lv,
                            flpq_pkg::wrap_idx(head_reg[up_lv], count_reg[up_lv]));
                    count_next[up_lv] = count_reg[up_lv] + CW'(1);
                end
                else
                begin
                    if (match)
                        full_next = 1'b1;
                    we    = 1'b1;
                    waddr = flpq_pkg::slot_addr(lv_reg,
                            flpq_pkg::wrap_idx(head_reg[lv_reg], count_reg[lv_reg]));
                    count_next[lv_reg] = count_reg[lv_reg] + CW'(1);
                end
            end

            default:
            begin
                state_next = flpq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= flpq_pkg::S_IDLE;
            strobe_reg <= 1'b0;
            for (int l = 0; l < NL; l++)
            begin
                head_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        promote_reg <= promote_next;
        snd_reg     <= snd_next;
        lv_reg      <= lv_next;
        n_reg       <= n_next;
        j_reg       <= j_next;
        cnt_reg     <= cnt_next;
        moved_reg   <= moved_next;
        full_reg    <= full_next;
        alast_reg   <= alast_next;
        status_reg  <= status_next;
        sender_reg  <= sender_next;
        level_reg   <= level_next;
        payload_reg <= payload_next;
        mcount_reg  <= mcount_next;
        last_reg    <= last_next;
    end

    assign busy        = (state_reg != flpq_pkg::S_IDLE);
    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign out_sender  = sender_reg;
    assign out_level   = level_reg;
    assign out_payload = payload_reg;
    assign moved_count = mcount_reg;
    assign last        = last_reg;

endmodule

### rtl/flpq_checker.sv
// ----------------------------------------------------------------------------
// flpq_checker
// Port-level checks on request and result sequencing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flpq_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       strobe,
    input logic [1:0] status,
    input logic       last
);

    // every taken request gives a result or keeps the block busy
    `ASSERT_NEXT(a_req_progress, start && !busy, strobe || busy)
    // an empty announce is always a single result
    `ASSERT_IMPL(a_empty_last, strobe && status == flpq_pkg::ST_EMPTY, last)
    // level-full only comes from single-result requests
    `ASSERT_IMPL(a_full_last, strobe && status == flpq_pkg::ST_FULL, last)
    // more results to come: block stays busy
    `ASSERT_IMPL(a_more_busy, strobe && !last, busy)

endmodule

bind five_level_priority_queue_purge flpq_checker u_flpq_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .status (status),
    .last   (last)
);

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the five level priority queue: a directed table,
// then random send / announce / remove / promote requests, every result
// checked field by field against a behavioural copy of the queue.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NDIR       = 21;
    localparam int NRAND      = 110;
    localparam int IDLE_LIMIT = 2000;

    typedef struct packed {
        flpq_pkg::kind_t   k;
        logic [15:0]       snd;
        logic [2:0]        lvl;
        logic [31:0]       pay;
        logic [6:0]        cnt;
        logic              typed;
        flpq_pkg::status_t tst;
    } req_t;

    typedef struct packed {
        flpq_pkg::status_t st;
        logic [15:0]       snd;
        logic [2:0]        lvl;
        logic [31:0]       pay;
        logic [6:0]        moved;
        logic              last;
    } res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  kind = '0;
    logic [15:0] sender_id = '0;
    logic [2:0]  level = '0;
    logic [31:0] payload = '0;
    logic [6:0]  announce_count = '0;
    logic        strobe;
    logic [1:0]  status;
    logic [15:0] out_sender;
    logic [2:0]  out_level;
    logic [31:0] out_payload;
    logic [6:0]  moved_count;
    logic        last;

    logic              typed_en = 1'b0;
    flpq_pkg::status_t typed_st = flpq_pkg::ST_OK;

    // behavioural copy of the queue
    logic [47:0] q_mem [flpq_pkg::LEVELS][flpq_pkg::LEVEL_DEPTH];
    int          q_head [flpq_pkg::LEVELS];
    int          q_cnt [flpq_pkg::LEVELS];
    res_t        pending_res [$];
    int          errors = 0;
    int          idle_cycles = 0;

    req_t dir_tab [NDIR];

    always #4 clk = ~clk;

    five_level_priority_queue_purge dut (.*);

    function automatic logic [47:0] q_pop(int lv);
        logic [47:0] e;
        e = q_mem[lv][q_head[lv]];
        q_head[lv] = (q_head[lv] + 1) % flpq_pkg::LEVEL_DEPTH;
        q_cnt[lv]--;
        return e;
    endfunction

    function automatic void q_push(int lv, logic [47:0] e);
        q_mem[lv][(q_head[lv] + q_cnt[lv]) % flpq_pkg::LEVEL_DEPTH] = e;
        q_cnt[lv]++;
    endfunction

    // apply one request to the copy and queue the results it should give
    function automatic void queue_apply(req_t r);
        res_t        o;
        logic [47:0] e;
        int          n, moved, left, nres;
        o = '0;
        o.last = 1'b1;
        moved = 0;
        case (r.k)
            flpq_pkg::KIND_SEND:
            begin
                if (r.lvl >= flpq_pkg::LEVELS || q_cnt[r.lvl] >= flpq_pkg::LEVEL_DEPTH)
                    o.st = flpq_pkg::ST_FULL;
                else
                    q_push(r.lvl, {r.snd, r.pay});
                pending_res.push_back(o);
            end
            flpq_pkg::KIND_ANNOUNCE:
            begin
                left = (r.cnt > flpq_pkg::MAX_RESULTS) ? flpq_pkg::MAX_RESULTS : r.cnt;
                nres = 0;
                for (int lv = 0; lv < flpq_pkg::LEVELS; lv++)
                    while (q_cnt[lv] != 0 && left != 0)
                    begin
                        e = q_pop(lv);
                        o = '0;
                        o.snd = e[47:32];
                        o.lvl = lv[2:0];
                        o.pay = e[31:0];
                        pending_res.push_back(o);
                        nres++;
                        left--;
                    end
                if (nres == 0)
                begin
                    o = '0;
                    o.st = flpq_pkg::ST_EMPTY;
                    pending_res.push_back(o);
                end
                pending_res[$].last = 1'b1;
            end
            flpq_pkg::KIND_REMOVE:
            begin
                for (int lv = 0; lv < flpq_pkg::LEVELS; lv++)
                begin
                    n = q_cnt[lv];
                    for (int j = 0; j < n; j++)
                    begin
                        e = q_pop(lv);
                        if (e[47:32] == r.snd)
                            moved++;
                        else
                            q_push(lv, e);
                    end
                end
                o.moved = (moved > 127) ? 7'd127 : moved[6:0];
                pending_res.push_back(o);
            end
            default:
            begin
                for (int lv = 1; lv < flpq_pkg::LEVELS; lv++)
                begin
                    n = q_cnt[lv];
                    for (int j = 0; j < n; j++)
                    begin
                        e = q_pop(lv);
                        if (e[47:32] == r.snd && q_cnt[lv-1] < flpq_pkg::LEVEL_DEPTH)
                        begin
                            q_push(lv - 1, e);
                            moved++;
                        end
                        else
                        begin
                            if (e[47:32] == r.snd)
                                o.st = flpq_pkg::ST_FULL;
                            q_push(lv, e);
                        end
                    end
                end
                o.moved = (moved > 127) ? 7'd127 : moved[6:0];
                pending_res.push_back(o);
            end
        endcase
    endfunction

    // result checking, request capture and watchdog
    always @(posedge clk)
    begin
        res_t x;
        req_t r;
        if (rst_n)
        begin
            if (strobe || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            if (strobe)
            begin
                if (pending_res.size() == 0)
                begin
                    $error("unexpected result, status %0d", status);
                    errors++;
                end
                else
                begin
                    x = pending_res.pop_front();
                    if (status !== x.st)
                    begin
                        $error("status exp %0d got %0d", x.st, status);
                        errors++;
                    end
                    if (out_sender !== x.snd)
                    begin
                        $error("out_sender exp %h got %h", x.snd, out_sender);
                        errors++;
                    end
                    if (out_level !== x.lvl)
                    begin
                        $error("out_level exp %0d got %0d", x.lvl, out_level);
                        errors++;
                    end
                    if (out_payload !== x.pay)
                    begin
                        $error("out_payload exp %h got %h", x.pay, out_payload);
                        errors++;
                    end
                    if (moved_count !== x.moved)
                    begin
                        $error("moved_count exp %0d got %0d", x.moved, moved_count);
                        errors++;
                    end
                    if (last !== x.last)
                    begin
                        $error("last exp %0d got %0d", x.last, last);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                r = '0;
                r.k   = flpq_pkg::kind_t'(kind);
                r.snd = sender_id;
                r.lvl = level;
                r.pay = payload;
                r.cnt = announce_count;
                queue_apply(r);
                // hand-typed status for the table rows that carry one
                if (typed_en)
                    pending_res[$].st = typed_st;
            end
        end
    end

    task automatic issue(req_t r);
        int gap;
        gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        kind           <= r.k;
        sender_id      <= r.snd;
        level          <= r.lvl;
        payload        <= r.pay;
        announce_count <= r.cnt;
        typed_en       <= r.typed;
        typed_st       <= r.tst;
        do
            @(posedge clk);
        while (busy);
    endtask

    function automatic logic [15:0] pick_sender();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            5: return 16'($urandom);
            default: return 16'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic req_t random_req();
        req_t r;
        int   p;
        r = '0;
        r.snd = pick_sender();
        r.pay = $urandom;
        r.lvl = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
        p = $urandom_range(0, 99);
        if (p < 55)
            r.k = flpq_pkg::KIND_SEND;
        else if (p < 70)
        begin
            r.k = flpq_pkg::KIND_ANNOUNCE;
            case ($urandom_range(0, 9))
                0: r.cnt = 7'd0;
                1: r.cnt = 7'd64;
                2: r.cnt = 7'd127;
                3: r.cnt = 7'($urandom);
                default: r.cnt = 7'($urandom_range(1, 8));
            endcase
        end
        else if (p < 80)
            r.k = flpq_pkg::KIND_REMOVE;
        else
            r.k = flpq_pkg::KIND_PROMOTE;
        if (r.k != flpq_pkg::KIND_ANNOUNCE)
            r.cnt = 7'($urandom);
        return r;
    endfunction

    initial
    begin
        req_t r;
        dir_tab = '{
            '{flpq_pkg::KIND_ANNOUNCE, 16'h0000, 3'd0, 32'h0, 7'd5, 1'b1,
              flpq_pkg::ST_EMPTY},
            '{flpq_pkg::KIND_SEND, 16'h0001, 3'd5, 32'h1234, 7'd0, 1'b1,
              flpq_pkg::ST_FULL},
            '{flpq_pkg::KIND_SEND, 16'h0001, 3'd7, 32'h1234, 7'd0, 1'b1,
              flpq_pkg::ST_FULL},
            '{flpq_pkg::KIND_SEND, 16'h0000, 3'd0, 32'h0, 7'd0, 1'b1,
              flpq_pkg::ST_OK},
            '{flpq_pkg::KIND_SEND, 16'hFFFF, 3'd4, 32'hFFFFFFFF, 7'd127, 1'b1,
              flpq_pkg::ST_OK},
            '{flpq_pkg::KIND_SEND, 16'hFFFF, 3'd4, 32'hA5A5A5A5, 7'd0, 1'b1,
              flpq_pkg::ST_OK},
            '{flpq_pkg::KIND_SEND, 16'h0002, 3'd4, 32'h5A5A5A5A, 7'd0, 1'b1,
              flpq_pkg::ST_OK},
            '{flpq_pkg::KIND_SEND, 16'h0002, 3'd1, 32'h00000001, 7'd0, 1'b1,
              flpq_pkg::ST_OK},
            '{flpq_pkg::KIND_SEND, 16'hFFFF, 3'd2, 32'h80000000, 7'd0, 1'b1,
              flpq_pkg::ST_OK},
            '{flpq_pkg::KIND_SEND, 16'h0003, 3'd3, 32'h7FFFFFFF, 7'd0, 1'b1,
              flpq_pkg::ST_OK},
            '{flpq_pkg::KIND_ANNOUNCE, 16'h0000, 3'd0, 32'h0, 7'd0, 1'b1,
              flpq_pkg::ST_EMPTY},
            '{flpq_pkg::KIND_PROMOTE, 16'hFFFF, 3'd0, 32'h0, 7'd0, 1'b0,
              flpq_pkg::ST_OK},
            '{flpq_pkg::KIND_PROMOTE, 16'h0002, 3'd0, 32'h0, 7'd0, 1'b0,
              flpq_pkg::ST_OK},
            '{flpq_pkg::KIND_REMOVE, 16'h1234, 3'd0, 32'h0, 7'd0, 1'b0,
              flpq_pkg::ST_OK},
            '{flpq_pkg::KIND_REMOVE, 16'hFFFF, 3'd0, 32'h0, 7'd0, 1'b0,
              flpq_pkg::ST_OK},
            '{flpq_pkg::KIND_ANNOUNCE, 16'h0000, 3'd0, 32'h0, 7'd1, 1'b0,
              flpq_pkg::ST_OK},
            '{flpq_pkg::KIND_SEND, 16'h0004, 3'd0, 32'hDEADBEEF, 7'd0, 1'b1,
              flpq_pkg::ST_OK},
            '{flpq_pkg::KIND_SEND, 16'h0004, 3'd6, 32'hDEADBEEF, 7'd0, 1'b1,
              flpq_pkg::ST_FULL},
            '{flpq_pkg::KIND_ANNOUNCE, 16'h0000, 3'd0, 32'h0, 7'd127, 1'b0,
              flpq_pkg::ST_OK},
            '{flpq_pkg::KIND_ANNOUNCE, 16'h0000, 3'd0, 32'h0, 7'd64, 1'b1,
              flpq_pkg::ST_EMPTY},
            '{flpq_pkg::KIND_ANNOUNCE, 16'hFFFF, 3'd7, 32'hFFFFFFFF, 7'd1, 1'b1,
              flpq_pkg::ST_EMPTY}
        };
        for (int lv = 0; lv < flpq_pkg::LEVELS; lv++)
        begin
            q_head[lv] = 0;
            q_cnt[lv] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            issue(dir_tab[i]);

        for (int i = 0; i < NRAND; i++)
        begin
            if (i == 80)
            begin
                // hold off until the queue of results drains
                start <= 1'b0;
                @(posedge clk);
                while (pending_res.size() != 0)
                    @(posedge clk);
            end
            if (i % 60 == 20)
            begin
                // burst onto one level so that it fills and overflows
                r = random_req();
                r.k = flpq_pkg::KIND_SEND;
                r.lvl = 3'($urandom_range(0, 4));
                for (int j = 0; j < flpq_pkg::LEVEL_DEPTH + 2; j++)
                begin
                    r.snd = pick_sender();
                    r.pay = $urandom;
                    issue(r);
                end
            end
            issue(random_req());
        end
        start <= 1'b0;
        @(posedge clk);
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && pending_res.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl
rtl/flpq_pkg.sv
rtl/five_level_priority_queue_purge.sv
rtl/flpq_checker.sv
tb/tb_top.sv
